>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL, clocked on clk; BCE_ASSERT is held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while rst is high.
`define BCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds through reset.
`define BCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bce_pkg.sv
// Types, constants and tables of the Bezier curve evaluator.
`timescale 1ns / 1ps

package bce_pkg;

  localparam int MAX_POINTS  = 16;
  localparam int T_FRAC_BITS = 16;

  localparam int PIDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W   = 5;
  localparam int COORD_W = 32;
  localparam int T_W     = T_FRAC_BITS + 1;
  // largest binomial for sixteen points is C(15,7) = 6435
  localparam int BINOM_W = 13;
  localparam int W_W     = BINOM_W + T_FRAC_BITS;
  localparam int PROD_W  = COORD_W + W_W + 1;
  localparam int ACC_W   = PROD_W + PIDX_W;
  localparam int RND_W   = ACC_W - T_FRAC_BITS;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [T_W-1:0] ONE_Q = T_W'(1) << T_FRAC_BITS;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [PADDR_W-3:0] REG_POINT_COUNT = '0;

  typedef struct packed {
    logic                       mode;
    logic [3:0]                 point_index;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic [T_W-1:0]             param_t;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POINT,
    ST_STEP,
    ST_PROD,
    ST_ACC,
    ST_ROUND,
    ST_DONE
  } bce_state_t;

  typedef struct packed {
    logic              ram_we;
    logic [PIDX_W-1:0] rd_idx;
    logic [PIDX_W-1:0] n_last;
    logic              load_t;
    logic              clear_acc;
    logic              load_w;
    logic              step_w;
    logic              sel_t;
    logic              take_prod;
    logic              accum;
    logic              round;
    logic              load_out;
  } cmd_t;

  typedef logic [MAX_POINTS-1:0][MAX_POINTS-1:0][BINOM_W-1:0] binom_tab_t;

  // Pascal's triangle, row r holds C(r, c)
  function automatic binom_tab_t build_binom();
    binom_tab_t tab;
    tab = '0;
    for (int r = 0; r < MAX_POINTS; r++) begin
      for (int c = 0; c <= r; c++) begin
        if (c == 0 || c == r) begin
          tab[r][c] = BINOM_W'(1);
        end else begin
          tab[r][c] = tab[r-1][c-1] + tab[r-1][c];
        end
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM_TAB = build_binom();

endpackage

>>> rtl/bezier_curve_evaluator_core.sv
// Bezier curve evaluator: top level with configuration port, sequencer and datapath.
//
// Input items on item/item_valid/item_stall. A load item (mode 0) writes one
// control point (x, y) at point_index into the point store in the cycle it
// is accepted and gives no result. A sample item (mode 1) gives one result
// item on result/result_valid/result_stall: the curve point at param_t,
// saturated to 1.0, over the first point_count points in Bernstein form.
// With n points in use (point_count, capped at sixteen) each point has its binomial
// weight fetched and multiplied by its factors of t and 1-t on the one weight
// multiplier, and its coordinate products are taken and added in; the sum is then
// rounded into the output register. A sample occupies the block until its result
// is written out; a load does not. item_stall is high while a sample is being
// worked on. The result sits in an output register, so a load can be taken while
// it waits; a finished sample waits for a stalled result to be taken before it is
// written out. point_count is written over the APB port at address 0, only while
// idle: the user must keep to this, as the block does not enforce it. Reset clears
// point_count and the handshake state; the point store is not cleared, and every
// point in use must have been loaded before sampling.
`timescale 1ns / 1ps

module bezier_curve_evaluator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  bce_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output bce_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bce_pkg::PADDR_W-1:0]   paddr,
  input  logic [bce_pkg::PDATA_W-1:0]   pwdata,
  output logic [bce_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [bce_pkg::CNT_W-1:0] point_count;
  logic                      reg_sel;
  bce_pkg::cmd_t             cmd;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[bce_pkg::PADDR_W-1:2] == bce_pkg::REG_POINT_COUNT);
  assign prdata  = reg_sel ? {(bce_pkg::PDATA_W - bce_pkg::CNT_W)'(0), point_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      point_count <= pwdata[bce_pkg::CNT_W-1:0];
    end
  end

  bce_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_mode    (item.mode),
    .item_index   (item.point_index),
    .point_count  (point_count),
    .result_stall (result_stall),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  bce_dp u_dp (
    .clk    (clk),
    .item   (item),
    .cmd    (cmd),
    .result (result)
  );

`include "assert_macros.svh"

  `BCE_ASSERT(a_no_overwrite, cmd.load_out |-> (!result_valid || !result_stall), "pending result overwritten")
  `BCE_ASSERT(a_quiet_on_accept, (item_valid && !item_stall) |-> !(cmd.step_w || cmd.take_prod || cmd.accum || cmd.round), "item accepted mid-sample")
  `BCE_ASSERT(a_result_from_load, $rose(result_valid) |-> $past(cmd.load_out), "result valid without output load")
  `BCE_ASSERT_ALWAYS(a_reset_idle, rst |=> (!result_valid && !item_stall), "not idle after reset")

endmodule

>>> rtl/bce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bce_ctrl.sv
// Sequencer of the evaluator: handshakes, point and factor counters, datapath commands.
`timescale 1ns / 1ps

module bce_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic                        item_mode,
  input  logic [3:0]                  item_index,
  input  logic [bce_pkg::CNT_W-1:0]   point_count,
  input  logic                        result_stall,
  output logic                        item_stall,
  output logic                        result_valid,
  output bce_pkg::cmd_t               cmd
);

  bce_pkg::bce_state_t state, state_next;

  logic [bce_pkg::PIDX_W-1:0] i, i_next;
  logic [bce_pkg::PIDX_W-1:0] k, k_next;
  logic [bce_pkg::CNT_W-1:0]  n, n_next;
  logic [bce_pkg::CNT_W-1:0]  n_clamped;
  logic                       accept;
  logic                       out_free;

  assign n_clamped = (point_count > bce_pkg::CNT_W'(bce_pkg::MAX_POINTS)) ?
                     bce_pkg::CNT_W'(bce_pkg::MAX_POINTS) : point_count;
  assign accept    = item_valid && !item_stall;
  assign out_free  = !result_valid || !result_stall;
  assign item_stall = (state != bce_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bce_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i <= i_next;
    k <= k_next;
    n <= n_next;
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    k_next     = k;
    n_next     = n;
    cmd        = '0;
    cmd.rd_idx = i;
    cmd.n_last = bce_pkg::PIDX_W'(n - bce_pkg::CNT_W'(1));

    case (state)
      bce_pkg::ST_IDLE: begin
        if (accept && item_mode == bce_pkg::MODE_LOAD) begin
          cmd.ram_we = ({1'b0, item_index} < 5'(bce_pkg::MAX_POINTS));
        end else if (accept) begin
          cmd.load_t    = 1'b1;
          cmd.clear_acc = 1'b1;
          i_next        = '0;
          n_next        = n_clamped;
          state_next    = (n_clamped == '0) ? bce_pkg::ST_ROUND : bce_pkg::ST_POINT;
        end
      end
      bce_pkg::ST_POINT: begin
        cmd.load_w = 1'b1;
        k_next     = '0;
        state_next = (n > bce_pkg::CNT_W'(1)) ? bce_pkg::ST_STEP : bce_pkg::ST_PROD;
      end
      bce_pkg::ST_STEP: begin
        // i factors of t first, then the rest of (1-t)
        cmd.step_w = 1'b1;
        cmd.sel_t  = (k < i);
        k_next     = k + 1'b1;
        if (bce_pkg::CNT_W'(k) + bce_pkg::CNT_W'(2) == n) begin
          state_next = bce_pkg::ST_PROD;
        end
      end
      bce_pkg::ST_PROD: begin
        cmd.take_prod = 1'b1;
        state_next    = bce_pkg::ST_ACC;
      end
      bce_pkg::ST_ACC: begin
        cmd.accum = 1'b1;
        if (bce_pkg::CNT_W'(i) + bce_pkg::CNT_W'(1) == n) begin
          state_next = bce_pkg::ST_ROUND;
        end else begin
          i_next     = i + 1'b1;
          state_next = bce_pkg::ST_POINT;
        end
      end
      bce_pkg::ST_ROUND: begin
        cmd.round  = 1'b1;
        state_next = bce_pkg::ST_DONE;
      end
      bce_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = bce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bce_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/bce_dp.sv
// Datapath: point store, weight multiplier, coordinate products, sums and output rounding.
`timescale 1ns / 1ps

module bce_dp (
  input  logic            clk,
  input  bce_pkg::item_t  item,
  input  bce_pkg::cmd_t   cmd,
  output bce_pkg::result_t result
);

  localparam int WMUL_W = bce_pkg::W_W + bce_pkg::T_W;

  logic [bce_pkg::T_W-1:0]   t_sat, t_reg, u_reg, factor;
  logic [bce_pkg::W_W-1:0]   w;
  logic [WMUL_W-1:0]         wmul, wsum;
  logic [2*bce_pkg::COORD_W-1:0] pt;
  logic signed [bce_pkg::COORD_W-1:0] pt_x, pt_y;
  logic signed [bce_pkg::PROD_W-1:0] prod_x, prod_y;
  logic signed [bce_pkg::ACC_W-1:0]  acc_x, acc_y, rsum_x, rsum_y;
  logic signed [bce_pkg::RND_W-1:0]  rnd_x, rnd_y;

  function automatic logic signed [bce_pkg::COORD_W-1:0] sat_coord(
    input logic signed [bce_pkg::RND_W-1:0] v
  );
    logic signed [bce_pkg::RND_W-1:0] hi, lo;
    hi = bce_pkg::RND_W'({1'b0, {(bce_pkg::COORD_W-1){1'b1}}});
    lo = -hi - bce_pkg::RND_W'(1);
    if (v > hi) begin
      return hi[bce_pkg::COORD_W-1:0];
    end else if (v < lo) begin
      return lo[bce_pkg::COORD_W-1:0];
    end
    return v[bce_pkg::COORD_W-1:0];
  endfunction

  bce_ram #(
    .WIDTH (2 * bce_pkg::COORD_W),
    .DEPTH (bce_pkg::MAX_POINTS)
  ) u_points (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (item.point_index[bce_pkg::PIDX_W-1:0]),
    .wdata ({item.point_x, item.point_y}),
    .raddr (cmd.rd_idx),
    .rdata (pt)
  );

  assign pt_x = pt[2*bce_pkg::COORD_W-1:bce_pkg::COORD_W];
  assign pt_y = pt[bce_pkg::COORD_W-1:0];

  assign t_sat  = (item.param_t > bce_pkg::ONE_Q) ? bce_pkg::ONE_Q : item.param_t;
  assign factor = cmd.sel_t ? t_reg : u_reg;

  // w * f rounded half up; f is at most one, so the result never outgrows w
  assign wmul = WMUL_W'(w) * WMUL_W'(factor);
  assign wsum = wmul + WMUL_W'(bce_pkg::ONE_Q >> 1);

  assign rsum_x = acc_x + bce_pkg::ACC_W'(bce_pkg::ONE_Q >> 1);
  assign rsum_y = acc_y + bce_pkg::ACC_W'(bce_pkg::ONE_Q >> 1);

  always_ff @(posedge clk) begin
    if (cmd.load_t) begin
      t_reg <= t_sat;
      u_reg <= bce_pkg::ONE_Q - t_sat;
    end
    if (cmd.load_w) begin
      w <= bce_pkg::W_W'(bce_pkg::BINOM_TAB[cmd.n_last][cmd.rd_idx]) << bce_pkg::T_FRAC_BITS;
    end else if (cmd.step_w) begin
      w <= wsum[bce_pkg::W_W+bce_pkg::T_FRAC_BITS-1:bce_pkg::T_FRAC_BITS];
    end
    if (cmd.take_prod) begin
      prod_x <= pt_x * $signed({1'b0, w});
      prod_y <= pt_y * $signed({1'b0, w});
    end
    if (cmd.clear_acc) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (cmd.accum) begin
      acc_x <= acc_x + {{bce_pkg::PIDX_W{prod_x[bce_pkg::PROD_W-1]}}, prod_x};
      acc_y <= acc_y + {{bce_pkg::PIDX_W{prod_y[bce_pkg::PROD_W-1]}}, prod_y};
    end
    // floor of (sum + half) / one
    if (cmd.round) begin
      rnd_x <= rsum_x[bce_pkg::ACC_W-1:bce_pkg::T_FRAC_BITS];
      rnd_y <= rsum_y[bce_pkg::ACC_W-1:bce_pkg::T_FRAC_BITS];
    end
    if (cmd.load_out) begin
      result.curve_x <= sat_coord(rnd_x);
      result.curve_y <= sat_coord(rnd_y);
    end
  end

endmodule
